>>> sv/obef_pkg.sv
`timescale 1ns / 1ps

package obef_pkg;

  // fixed field widths
  localparam int CELL_CODE_W = 8;
  localparam int NEW_CODE_W  = 12;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;

  // default sizes
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_CODE_BITS  = 8;

  // smallest usable grid dimension (one border on each side plus one cell)
  localparam int MIN_DIM = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // fluid neighbour bits of the edge pattern
  localparam logic [3:0] EDGE_NONE  = 4'b0000;
  localparam logic [3:0] EDGE_LEFT  = 4'b1000;
  localparam logic [3:0] EDGE_RIGHT = 4'b0100;
  localparam logic [3:0] EDGE_UP    = 4'b0010;
  localparam logic [3:0] EDGE_DOWN  = 4'b0001;

  // result codes
  localparam logic [4:0] CODE_BAD        = 5'd0;
  localparam logic [4:0] CODE_DOWN       = 5'd9;
  localparam logic [4:0] CODE_UP         = 5'd7;
  localparam logic [4:0] CODE_RIGHT      = 5'd5;
  localparam logic [4:0] CODE_RIGHT_DOWN = 5'd17;
  localparam logic [4:0] CODE_RIGHT_UP   = 5'd15;
  localparam logic [4:0] CODE_LEFT       = 5'd3;
  localparam logic [4:0] CODE_LEFT_DOWN  = 5'd13;
  localparam logic [4:0] CODE_LEFT_UP    = 5'd11;
  localparam logic [NEW_CODE_W-1:0] CODE_INTERIOR = 12'd1;

  // control that travels with an item through the first stage
  typedef struct packed {
    logic has_res;     // item produces a result for the row below
    logic write_en;    // item stores its cell in the line buffer
    logic drain;       // item drains the top row
    logic first_col;   // no left neighbour
    logic last_col;    // no right neighbour
    logic has_down;    // down neighbour lies inside the grid
    logic last_frame;  // result is the final cell of the grid
  } seq_ctl_t;

  // fixed code of an admissible edge pattern, CODE_BAD otherwise
  function automatic logic [4:0] edge_code(input logic [3:0] pat);
    logic [4:0] code;
    case (pat)
      EDGE_DOWN:              code = CODE_DOWN;
      EDGE_UP:                code = CODE_UP;
      EDGE_RIGHT:             code = CODE_RIGHT;
      EDGE_RIGHT | EDGE_DOWN: code = CODE_RIGHT_DOWN;
      EDGE_RIGHT | EDGE_UP:   code = CODE_RIGHT_UP;
      EDGE_LEFT:              code = CODE_LEFT;
      EDGE_LEFT | EDGE_DOWN:  code = CODE_LEFT_DOWN;
      EDGE_LEFT | EDGE_UP:    code = CODE_LEFT_UP;
      default:                code = CODE_BAD;
    endcase
    return code;
  endfunction

endpackage

>>> sv/obef_seq.sv
`timescale 1ns / 1ps

module obef_seq
  import obef_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int CODE_BITS  = DEF_CODE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  input  logic [CELL_CODE_W-1:0]        cell_code,
  input  logic                          flush,
  input  logic                          s1_en,
  output logic                          s1_load,
  output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  output logic                          s1_valid,
  output seq_ctl_t                      s1_ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]  s1_col,
  output logic [CODE_BITS-1:0]          s1_code
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WidW = $clog2(MAX_WIDTH + 1);
  localparam int RowW = $clog2(MAX_HEIGHT + 1);

  logic [WidW-1:0] grid_w;
  logic [RowW-1:0] grid_h;
  logic [ColW-1:0] col;
  logic [RowW-1:0] row;

  logic [WidW-1:0] w_clamped;
  logic [RowW-1:0] h_clamped;
  logic            drain;
  logic            last_col;
  logic            active;
  seq_ctl_t        ctl_next;

  // clamp written dimensions to the usable range
  always_comb begin
    if (cfg_data < CFG_DATA_W'(MIN_DIM)) begin
      w_clamped = WidW'(MIN_DIM);
    end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
      w_clamped = WidW'(MAX_WIDTH);
    end else begin
      w_clamped = WidW'(cfg_data);
    end
    if (cfg_data < CFG_DATA_W'(MIN_DIM)) begin
      h_clamped = RowW'(MIN_DIM);
    end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
      h_clamped = RowW'(MAX_HEIGHT);
    end else begin
      h_clamped = RowW'(cfg_data);
    end
  end

  // position decode of the next item
  always_comb begin
    drain    = (row == grid_h);
    last_col = ((WidW'(col) + WidW'(1)) == grid_w);
    active   = drain || !flush;
    s1_load  = in_valid && s1_en && active;
    rd_addr  = last_col ? '0 : col + ColW'(1);

    ctl_next.has_res    = drain || (row != '0);
    ctl_next.write_en   = !drain;
    ctl_next.drain      = drain;
    ctl_next.first_col  = (col == '0);
    ctl_next.last_col   = last_col;
    ctl_next.has_down   = drain || (row > RowW'(1));
    ctl_next.last_frame = drain && last_col;
  end

  // dimension registers and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w <= WidW'(MAX_WIDTH);
      grid_h <= RowW'(MAX_HEIGHT);
      col    <= '0;
      row    <= '0;
    end else if (cfg_write && (cfg_index == REG_GRID_WIDTH)) begin
      grid_w <= w_clamped;
      col    <= '0;
      row    <= '0;
    end else if (cfg_write && (cfg_index == REG_GRID_HEIGHT)) begin
      grid_h <= h_clamped;
      col    <= '0;
      row    <= '0;
    end else if (s1_load) begin
      if (last_col) begin
        col <= '0;
        row <= drain ? '0 : row + RowW'(1);
      end else begin
        col <= col + ColW'(1);
      end
    end
  end

  // first pipeline stage: valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid && active;
    end
  end

  // first pipeline stage: payload
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ctl  <= ctl_next;
      s1_col  <= col;
      s1_code <= CODE_BITS'(cell_code);
    end
  end

  // register write restarts the frame
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_write && ((cfg_index == REG_GRID_WIDTH) || (cfg_index == REG_GRID_HEIGHT))
    |=> (col == '0) && (row == '0))
    else $error("frame not restarted after register write");

  // row counter never passes the drain row
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row <= grid_h)
    else $error("row counter beyond grid height");

  // column counter stays inside the row
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    WidW'(col) < grid_w)
    else $error("column counter beyond grid width");

endmodule

>>> sv/obef_linebuf.sv
`timescale 1ns / 1ps

module obef_linebuf
  import obef_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int CODE_BITS = DEF_CODE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  input  logic                          s1_valid,
  input  seq_ctl_t                      s1_ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0]  s1_col,
  input  logic [CODE_BITS-1:0]          s1_code,
  input  logic                          s2_en,
  output logic                          s2_valid,
  output logic [CODE_BITS-1:0]          s2_center,
  output logic [3:0]                    s2_pattern,
  output logic                          s2_last
);

  // each entry holds one column: previous row in the upper half, the row before in the lower
  logic [2*CODE_BITS-1:0] mem [MAX_WIDTH];
  logic [2*CODE_BITS-1:0] rd_data;

  // sliding window over the previous row
  logic [CODE_BITS-1:0] win_l;
  logic [CODE_BITS-1:0] win_c;
  logic [CODE_BITS-1:0] win_d;

  logic [CODE_BITS-1:0] ahead_r1;
  logic [CODE_BITS-1:0] ahead_r2;
  logic                 s1_adv;
  logic [3:0]           pattern;

  assign ahead_r1 = rd_data[2*CODE_BITS-1:CODE_BITS];
  assign ahead_r2 = rd_data[CODE_BITS-1:0];
  assign s1_adv   = s1_valid && s2_en;

  // look-ahead read of the right neighbour column
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // shift the column down one row as the new cell arrives
  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctl.write_en) begin
      mem[s1_col] <= {s1_code, win_c};
    end
  end

  // window slides by one column per item
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_l <= win_c;
      win_c <= ahead_r1;
      win_d <= ahead_r2;
    end
  end

  // fluid neighbour pattern, outside neighbours masked
  always_comb begin
    pattern = EDGE_NONE;
    if (!s1_ctl.first_col && (win_l == '0)) begin
      pattern = pattern | EDGE_LEFT;
    end
    if (!s1_ctl.last_col && (ahead_r1 == '0)) begin
      pattern = pattern | EDGE_RIGHT;
    end
    if (!s1_ctl.drain && (s1_code == '0)) begin
      pattern = pattern | EDGE_UP;
    end
    if (s1_ctl.has_down && (win_d == '0)) begin
      pattern = pattern | EDGE_DOWN;
    end
  end

  // second pipeline stage: valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid && s1_ctl.has_res;
    end
  end

  // second pipeline stage: payload
  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_center  <= win_c;
      s2_pattern <= pattern;
      s2_last    <= s1_ctl.last_frame;
    end
  end

endmodule

>>> sv/obef_classify.sv
`timescale 1ns / 1ps

module obef_classify
  import obef_pkg::*;
#(
  parameter int CODE_BITS = DEF_CODE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s2_valid,
  input  logic [CODE_BITS-1:0]  s2_center,
  input  logic [3:0]            s2_pattern,
  input  logic                  s2_last,
  input  logic                  s3_en,
  output logic                  s3_valid,
  output logic [NEW_CODE_W-1:0] new_code,
  output logic                  bad_edges,
  output logic                  last_of_frame
);

  localparam int SumW = (CODE_BITS + 4 > NEW_CODE_W) ? CODE_BITS + 4 : NEW_CODE_W;

  logic [4:0]            tbl;
  logic [CODE_BITS-1:0]  base;
  logic [SumW-1:0]       sum;
  logic [NEW_CODE_W-1:0] code_next;
  logic                  bad_next;

  // 16 * (b - 1) plus the pattern code
  always_comb begin
    tbl  = edge_code(s2_pattern);
    base = s2_center - CODE_BITS'(1);
    sum  = SumW'({base, 4'b0000}) + SumW'(tbl);
  end

  // obstacle classification
  always_comb begin
    code_next = '0;
    bad_next  = 1'b0;
    if (s2_center != '0) begin
      if (s2_pattern == EDGE_NONE) begin
        code_next = CODE_INTERIOR;
      end else if (tbl != CODE_BAD) begin
        code_next = sum[NEW_CODE_W-1:0];
      end else begin
        bad_next = 1'b1;
      end
    end
  end

  // output stage: valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= s2_valid;
    end
  end

  // output stage: payload
  always_ff @(posedge clk) begin
    if (s3_en) begin
      new_code      <= code_next;
      bad_edges     <= bad_next;
      last_of_frame <= s2_last;
    end
  end

  // a flagged cell never carries a code
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    s3_valid && bad_edges |-> (new_code == '0))
    else $error("bad edge pattern with nonzero code");

endmodule

>>> sv/obstacle_edge_flag_classifier_top.sv
`timescale 1ns / 1ps

// Obstacle edge flag classifier.
// Cell codes enter on in_valid/in_stall in raster order, rows bottom to top,
// columns left to right; code 0 is fluid, nonzero is an obstacle with that
// boundary condition. Results leave on out_valid/out_stall: new_code,
// bad_edges and last_of_frame, the last set on the top right cell.
// Results lag the input by one row: the item at (row r, col c) releases the
// result of (row r-1, col c) on the outputs through three register stages,
// the first loaded at the edge that accepts the item. Rows 1 to
// height-1 each give one result per cell; after the last row, one row of
// items (any flush bit) drains the top row. flush items during the frame are
// taken and dropped. Grid width and height are written on the cfg port
// (index 0 and 1, clamped to 3..MAX) while idle; a write restarts the frame.
// Throughput is one item per clock unless out_stall backs up the pipeline,
// set by the line buffer doing one read and one write (at different columns)
// per cycle; the pipeline is three stages. Reset clears the counters and sets
// both dimensions to their maximum; the line buffer is not cleared and needs
// no clearing pass. When out_stall is high the full stages hold; in_stall
// rises once all three stages are full, so nothing is lost or repeated.
module obstacle_edge_flag_classifier_top
  import obef_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int CODE_BITS  = DEF_CODE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CELL_CODE_W-1:0] cell_code,
  input  logic                   flush,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [NEW_CODE_W-1:0]  new_code,
  output logic                   bad_edges,
  output logic                   last_of_frame
);

  localparam int ColW = $clog2(MAX_WIDTH);

  logic                 s1_en;
  logic                 s2_en;
  logic                 s3_en;
  logic                 s1_load;
  logic [ColW-1:0]      rd_addr;
  logic                 s1_valid;
  seq_ctl_t             s1_ctl;
  logic [ColW-1:0]      s1_col;
  logic [CODE_BITS-1:0] s1_code;
  logic                 s2_valid;
  logic [CODE_BITS-1:0] s2_center;
  logic [3:0]           s2_pattern;
  logic                 s2_last;
  logic                 s3_valid;

  // stall chain: a stage moves when the one after it is empty or moving
  assign s3_en     = !s3_valid || !out_stall;
  assign s2_en     = !s2_valid || s3_en;
  assign s1_en     = !s1_valid || s2_en;
  assign in_stall  = !s1_en;
  assign cfg_ready = 1'b1;
  assign out_valid = s3_valid;

  obef_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CODE_BITS  (CODE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .cell_code (cell_code),
    .flush     (flush),
    .s1_en     (s1_en),
    .s1_load   (s1_load),
    .rd_addr   (rd_addr),
    .s1_valid  (s1_valid),
    .s1_ctl    (s1_ctl),
    .s1_col    (s1_col),
    .s1_code   (s1_code)
  );

  obef_linebuf #(
    .MAX_WIDTH (MAX_WIDTH),
    .CODE_BITS (CODE_BITS)
  ) u_linebuf (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (s1_load),
    .rd_addr    (rd_addr),
    .s1_valid   (s1_valid),
    .s1_ctl     (s1_ctl),
    .s1_col     (s1_col),
    .s1_code    (s1_code),
    .s2_en      (s2_en),
    .s2_valid   (s2_valid),
    .s2_center  (s2_center),
    .s2_pattern (s2_pattern),
    .s2_last    (s2_last)
  );

  obef_classify #(
    .CODE_BITS (CODE_BITS)
  ) u_classify (
    .clk           (clk),
    .rst           (rst),
    .s2_valid      (s2_valid),
    .s2_center     (s2_center),
    .s2_pattern    (s2_pattern),
    .s2_last       (s2_last),
    .s3_en         (s3_en),
    .s3_valid      (s3_valid),
    .new_code      (new_code),
    .bad_edges     (bad_edges),
    .last_of_frame (last_of_frame)
  );

  // input only stalls when the first stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with empty first stage");

  // a result leaving frees room for a new item
  a_drain_frees: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |-> !in_stall)
    else $error("input stalled while output moves");

endmodule

>>> tb/obstacle_edge_flag_classifier_top_test.sv
`timescale 1ns / 1ps

module obstacle_edge_flag_classifier_top_test;
  import obef_pkg::*;

  localparam int RESET_CYCLES    = 10;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RANDOM_ITEMS    = 350;
  localparam int PRESSURE_AT     = 100;
  localparam int PRESSURE_CYCLES = 300;

  // register indexes past the two real ones, ignored by the block
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  // 6x5 plate, bottom row first: a 3x3 obstacle block that shows every
  // admissible pattern and the interior, an isolated cell on the right border
  // with an inadmissible pattern, and an obstacle in the top right corner
  localparam logic [CELL_CODE_W-1:0] SAMPLE_GRID [30] = '{
    8'd0, 8'd0,   8'd0, 8'd0,   8'd0, 8'd0,
    8'd0, 8'd1,   8'd2, 8'd255, 8'd0, 8'd0,
    8'd0, 8'd3,   8'd4, 8'd5,   8'd0, 8'd77,
    8'd0, 8'd128, 8'd1, 8'd255, 8'd0, 8'd0,
    8'd0, 8'd0,   8'd0, 8'd0,   8'd0, 8'd200
  };

  typedef struct packed {
    logic [NEW_CODE_W-1:0] code;
    logic                  bad;
    logic                  frame_end;
  } flag_result_t;

  // tracks the grid position and line buffers, predicts each classified flag
  class flag_checker;
    int unsigned used_w, used_h;
    int unsigned col, row;
    logic [CELL_CODE_W-1:0] line_buf [2][DEF_MAX_WIDTH];
    logic [4:0] edge_lut [16];
    flag_result_t expected_flags[$];
    int errors, checked, frames, bad_flags;

    function new();
      foreach (edge_lut[p]) edge_lut[p] = CODE_BAD;
      edge_lut[EDGE_DOWN]              = CODE_DOWN;
      edge_lut[EDGE_UP]                = CODE_UP;
      edge_lut[EDGE_RIGHT]             = CODE_RIGHT;
      edge_lut[EDGE_RIGHT | EDGE_DOWN] = CODE_RIGHT_DOWN;
      edge_lut[EDGE_RIGHT | EDGE_UP]   = CODE_RIGHT_UP;
      edge_lut[EDGE_LEFT]              = CODE_LEFT;
      edge_lut[EDGE_LEFT | EDGE_DOWN]  = CODE_LEFT_DOWN;
      edge_lut[EDGE_LEFT | EDGE_UP]    = CODE_LEFT_UP;
      foreach (line_buf[b, c]) line_buf[b][c] = '0;
      used_w = DEF_MAX_WIDTH;
      used_h = DEF_MAX_HEIGHT;
      col = 0;
      row = 0;
    endfunction

    function int unsigned fit_dim(logic [CFG_DATA_W-1:0] v, int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
    endfunction

    // a write to a real register restarts the frame
    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_GRID_WIDTH: used_w = fit_dim(val, DEF_MAX_WIDTH);
        REG_GRID_HEIGHT: used_h = fit_dim(val, DEF_MAX_HEIGHT);
        default: return;
      endcase
      col = 0;
      row = 0;
    endfunction

    // fluid neighbours of cell (r, c); neighbours off the grid do not count
    function logic [3:0] fluid_sides(int unsigned r, int unsigned c, bit has_up,
                                     logic [CELL_CODE_W-1:0] up);
      logic [3:0] p;
      p = EDGE_NONE;
      if (c > 0 && line_buf[r % 2][c - 1] == 0) p |= EDGE_LEFT;
      if (c + 1 < used_w && line_buf[r % 2][c + 1] == 0) p |= EDGE_RIGHT;
      if (has_up && up == 0) p |= EDGE_UP;
      if (r > 0 && line_buf[(r - 1) % 2][c] == 0) p |= EDGE_DOWN;
      return p;
    endfunction

    function flag_result_t grade(logic [CELL_CODE_W-1:0] center, logic [3:0] sides,
                                 bit frame_end);
      flag_result_t res;
      res.code = '0;
      res.bad = 1'b0;
      res.frame_end = frame_end;
      if (center != 0) begin
        if (sides == EDGE_NONE) begin
          res.code = CODE_INTERIOR;
        end else if (edge_lut[sides] != CODE_BAD) begin
          res.code = NEW_CODE_W'(16 * (int'(center) - 1) + int'(edge_lut[sides]));
        end else begin
          res.bad = 1'b1;
        end
      end
      return res;
    endfunction

    // returns 0 when the item is a flush dropped during the fill phase
    function bit note_input(logic [CELL_CODE_W-1:0] cell_val, logic flush_bit);
      if (col >= used_w || row > used_h) begin
        col = 0;
        row = 0;
      end
      if (row < used_h) begin
        if (flush_bit) return 1'b0;
        if (row >= 1) begin
          expected_flags.push_back(grade(line_buf[(row - 1) % 2][col],
                                         fluid_sides(row - 1, col, 1'b1, cell_val), 1'b0));
        end
        line_buf[row % 2][col] = cell_val;
        col++;
        if (col == used_w) begin
          col = 0;
          row++;
        end
      end else begin
        // drain the top row, cell and flush bit do not matter
        expected_flags.push_back(grade(line_buf[(used_h - 1) % 2][col],
                                       fluid_sides(used_h - 1, col, 1'b0, '0),
                                       col + 1 == used_w));
        col++;
        if (col == used_w) begin
          col = 0;
          row = 0;
        end
      end
      return 1'b1;
    endfunction

    task flag_error(string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [NEW_CODE_W-1:0] code, logic bad, logic frame_end);
      flag_result_t want;
      if (expected_flags.size() == 0) begin
        flag_error($sformatf("unexpected result new_code=%0d bad_edges=%0b last=%0b",
                             code, bad, frame_end));
        return;
      end
      want = expected_flags.pop_front();
      checked++;
      if (code !== want.code || bad !== want.bad || frame_end !== want.frame_end) begin
        flag_error($sformatf("new_code %0d/%0d bad_edges %0b/%0b last %0b/%0b (got/exp)",
                             code, want.code, bad, want.bad, frame_end, want.frame_end));
      end
      if (frame_end === 1'b1) frames++;
      if (bad === 1'b1) bad_flags++;
    endtask

    task close();
      flag_result_t want;
      while (expected_flags.size() != 0) begin
        want = expected_flags.pop_front();
        flag_error($sformatf("missing result new_code=%0d bad_edges=%0b last=%0b",
                             want.code, want.bad, want.frame_end));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [CELL_CODE_W-1:0] cell_code = '0;
  logic                   flush = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [NEW_CODE_W-1:0]  new_code;
  logic                   bad_edges;
  logic                   last_of_frame;

  flag_checker sb = new();
  bit quiet = 1'b0;
  int items_taken = 0;
  int cells_dropped = 0;
  int quiet_cycles = 0;

  obstacle_edge_flag_classifier_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cell_code     (cell_code),
    .flush         (flush),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .new_code      (new_code),
    .bad_edges     (bad_edges),
    .last_of_frame (last_of_frame)
  );

  always #1 clk = ~clk;

  // idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [CELL_CODE_W-1:0] random_cell(int obst_pct);
    int r;
    if ($urandom_range(0, 99) >= obst_pct) return '0;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd1;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(1, 255));
  endfunction

  // offer one item, hold it until taken
  task automatic push_item(input logic [CELL_CODE_W-1:0] c, input logic f);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_code <= c;
    flush <= f;
    do @(posedge clk); while (in_stall);
    items_taken++;
    if (!sb.note_input(c, f)) cells_dropped++;
  endtask

  // n items in raster order from wherever the frame stands
  task automatic send_cells(input int n, input int obst_pct, input int noise_pct);
    for (int i = 0; i < n; i++) begin
      if (sb.row < sb.used_h) begin
        if ($urandom_range(0, 99) < noise_pct) push_item(8'($urandom), 1'b1);
        push_item(random_cell(obst_pct), 1'b0);
      end else begin
        push_item(8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // wait for every result, then let the pipeline idle with no input
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_flags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off to back up the input
  initial begin : result_sink
    int hold;
    int seen;
    bit pressed;
    hold = 0;
    seen = 0;
    pressed = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_result(new_code, bad_edges, last_of_frame);
        seen++;
      end
      if (!pressed && seen >= PRESSURE_AT) begin
        pressed = 1'b1;
        hold = PRESSURE_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        hold = idle_len();
        out_stall <= (hold > 0);
        if (hold > 0) hold--;
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int r;
    int n;
    int random_start;
    logic [CFG_DATA_W-1:0] w_val, h_val;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: the start of the first row
    send_cells(40, 30, 3);
    settle();

    // small plate with every edge code, flush items mid-frame and in the drain
    cfg_write(REG_GRID_WIDTH, 11'd6);
    cfg_write(REG_GRID_HEIGHT, 11'd5);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 30; i++) begin
      if (i == 6 || i == 17) push_item(8'hFF, 1'b1);
      push_item(SAMPLE_GRID[i], 1'b0);
    end
    for (int i = 0; i < 6; i++) begin
      push_item((i % 2 == 1) ? 8'hFF : 8'h00, 1'((i / 2) % 2));
    end
    settle();

    // narrowest grid, one tall frame
    cfg_write(REG_GRID_HEIGHT, 11'd64);
    cfg_write(REG_GRID_WIDTH, 11'd3);
    cfg_valid <= 1'b0;
    send_cells(3 * (64 + 1), 40, 2);
    settle();

    // flattest grid, one wide frame without gaps
    quiet = 1'b1;
    cfg_write(REG_GRID_WIDTH, 11'd64);
    cfg_write(REG_GRID_HEIGHT, 11'd3);
    cfg_valid <= 1'b0;
    send_cells(64 * (3 + 1), 25, 2);
    settle();

    // random small frames, some cut short, some sizes out of range
    random_start = items_taken - cells_dropped;
    while (items_taken - cells_dropped - random_start < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 85) begin
        r = $urandom_range(0, 99);
        if (r < 70) w_val = 11'($urandom_range(3, 10));
        else if (r < 88) w_val = 11'($urandom_range(11, 48));
        else w_val = 11'($urandom_range(0, 2));
        r = $urandom_range(0, 99);
        if (r < 70) h_val = 11'($urandom_range(3, 8));
        else if (r < 85) h_val = 11'($urandom_range(9, 24));
        else if (r < 93) h_val = 11'($urandom_range(0, 2));
        else if (r < 96) h_val = 11'h7FF;
        else h_val = 11'($urandom_range(1025, 2046));
        if ($urandom_range(0, 1) == 1) begin
          cfg_write(REG_GRID_WIDTH, w_val);
          cfg_write(REG_GRID_HEIGHT, h_val);
        end else begin
          cfg_write(REG_GRID_HEIGHT, h_val);
          cfg_write(REG_GRID_WIDTH, w_val);
        end
        if ($urandom_range(0, 9) == 0) begin
          cfg_write(($urandom_range(0, 1) == 1) ? REG_SPARE_3 : REG_SPARE_2,
                    11'($urandom));
        end
        cfg_valid <= 1'b0;
      end
      if (sb.used_w * (sb.used_h + 1) > 240 || $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3 * sb.used_w);
      end else begin
        n = sb.used_w * (sb.used_h + 1);
      end
      send_cells(n, $urandom_range(0, 100), $urandom_range(0, 10));
      settle();
    end
    quiet = 1'b0;

    sb.close();
    $display("run: %0d items taken (%0d flush items dropped while filling), %0d flags checked",
             items_taken, cells_dropped, sb.checked);
    $display("run: %0d frames drained to the corner cell, %0d bad edge flags, %0d mismatches",
             sb.frames, sb.bad_flags, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
